// ----- hdl/lss_pkg.sv -----
`timescale 1ns / 1ps

package lss_pkg;

	// Array store geometry
	localparam int MAX_ELEMENTS = 1024;
	localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
	localparam int CNT_W        = ADDR_W + 1;

	// Field widths
	localparam int SAMPLE_W = 16;
	localparam int SUM_W    = 26;
	localparam int DIFF_W   = SUM_W + 1;
	localparam int LEN_W    = 11;

	// APB register file
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic [APB_ADDR_W-3:0] REG_THRESHOLD = '0;

	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic signed [DIFF_W-1:0] diff_t;

endpackage

// ----- hdl/longest_subarray_sum_at_most_k.sv -----
`timescale 1ns / 1ps

// Channel  | Handshake          | Payload
// ---------+--------------------+-----------------------------------
// in       | in_valid/in_ready  | sample[15:0] signed, is_last
// out      | out_valid/out_ready| best_length[10:0], overflowed
// cfg      | APB, pready high   | threshold at 0x0 (26-bit signed)
//
// Loading accepts one sample per cycle while in_ready is high. After the sample
// marked last, the block runs a check state, a suffix-min pass, a prime state,
// the walk and an emit state. The early case (total <= threshold) skips the
// pass and walk. Reset is asynchronous and clears all control state; no
// clearing pass is needed. in_ready is low while an array is resolved; a
// pending result waits in the output register while the next array loads.

module longest_subarray_sum_at_most_k
	import lss_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	// input channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [SAMPLE_W-1:0]   sample,
	input  logic                         is_last,
	// result channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [LEN_W-1:0]             best_length,
	output logic                         overflowed,
	// configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [APB_ADDR_W-1:0]        paddr,
	input  logic [APB_DATA_W-1:0]        pwdata,
	output logic [APB_DATA_W-1:0]        prdata,
	output logic                         pready
);

	localparam logic [2:0] ST_LOAD   = 3'd0;
	localparam logic [2:0] ST_CHECK  = 3'd1;
	localparam logic [2:0] ST_SUFFIX = 3'd2;
	localparam logic [2:0] ST_PRIME  = 3'd3;
	localparam logic [2:0] ST_WALK   = 3'd4;
	localparam logic [2:0] ST_EMIT   = 3'd5;

	logic [2:0]        state_q;
	sum_t              thr_q;
	sum_t              running_q;
	logic [CNT_W-1:0]  count_q;
	logic              drop_q;
	logic [CNT_W-1:0]  left_q;
	logic [CNT_W-1:0]  right_q;
	logic [LEN_W-1:0]  best_q;
	logic              out_valid_q;
	logic              sfx_valid_s1;

	logic [ADDR_W-1:0] sfx_addr_s1;
	logic [ADDR_W-1:0] rd_idx_q;
	sum_t              smin_q;
	sum_t              curp_q;
	logic [LEN_W-1:0]  result_len_q;
	logic [LEN_W-1:0]  best_length_q;
	logic              overflowed_q;

	// memories
	sum_t              prefix_mem [MAX_ELEMENTS];
	sum_t              smin_mem   [MAX_ELEMENTS];
	logic              p_we;
	logic [ADDR_W-1:0] p_waddr;
	logic [ADDR_W-1:0] p_raddr;
	sum_t              p_rdata_q;
	logic              sm_we;
	logic [ADDR_W-1:0] sm_waddr;
	sum_t              sm_wdata;
	logic [ADDR_W-1:0] sm_raddr;
	sum_t              sm_rdata_q;

	logic              in_fire;
	logic              has_room;
	sum_t              sample_ext;
	sum_t              new_sum;
	sum_t              sfx_min;
	diff_t             walk_diff;
	diff_t             thr_ext;
	logic              fits;
	logic              walk_more;
	logic [CNT_W-1:0]  r_plus1;
	logic [CNT_W-1:0]  r_plus2;
	logic [CNT_W-1:0]  l_plus1;
	logic [CNT_W-1:0]  span;
	logic              longer;
	logic              emit_go;
	logic              cfg_wr;

	// APB port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & (paddr[APB_ADDR_W-1:2] == REG_THRESHOLD);
	assign prdata = (paddr[APB_ADDR_W-1:2] == REG_THRESHOLD) ?
		{{(APB_DATA_W-SUM_W){thr_q[SUM_W-1]}}, thr_q} : '0;

	// Load path
	assign in_ready   = (state_q == ST_LOAD);
	assign in_fire    = in_valid & in_ready;
	assign has_room   = (count_q < CNT_W'(MAX_ELEMENTS));
	assign sample_ext = {{(SUM_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
	assign new_sum    = running_q + sample_ext;

	// Suffix pass: min of fetched prefix and the running minimum
	assign sfx_min = (p_rdata_q < smin_q) ? p_rdata_q : smin_q;

	// Walk step: smin_q holds suffix_min[right], curp_q holds prefix[left-1]
	assign walk_diff = {smin_q[SUM_W-1], smin_q} - {curp_q[SUM_W-1], curp_q};
	assign thr_ext   = {thr_q[SUM_W-1], thr_q};
	assign fits      = (walk_diff <= thr_ext);
	assign walk_more = (left_q < count_q) && (right_q < count_q);
	assign r_plus1   = right_q + 1'b1;
	assign r_plus2   = right_q + CNT_W'(2);
	assign l_plus1   = left_q + 1'b1;
	assign span      = r_plus1 - left_q;
	assign longer    = (r_plus1 > left_q) && (span[LEN_W-1:0] > best_q);

	assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	// Memory port steering; the walk prefetches the entries the next step needs
	always_comb begin
		p_we     = in_fire & has_room;
		p_waddr  = count_q[ADDR_W-1:0];
		p_raddr  = '0;
		sm_we    = 1'b0;
		sm_waddr = sfx_addr_s1;
		sm_wdata = sfx_min;
		sm_raddr = '0;
		case (state_q)
			ST_CHECK: begin
				sm_we    = !(running_q <= thr_q);
				sm_waddr = ADDR_W'(count_q - 1'b1);
				sm_wdata = running_q;
			end
			ST_SUFFIX: begin
				p_raddr = rd_idx_q - 1'b1;
				sm_we   = sfx_valid_s1;
			end
			ST_PRIME: begin
				p_raddr  = '0;
				sm_raddr = ADDR_W'(1);
			end
			ST_WALK: begin
				p_raddr  = fits ? left_q[ADDR_W-1:0] : l_plus1[ADDR_W-1:0];
				sm_raddr = fits ? r_plus2[ADDR_W-1:0] : r_plus1[ADDR_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// Prefix store
	always_ff @(posedge clk) begin
		if (p_we)
			prefix_mem[p_waddr] <= new_sum;
		p_rdata_q <= prefix_mem[p_raddr];
	end

	// Suffix-min store; it is only read in the prime state and the walk, after the pass has finished
	always_ff @(posedge clk) begin
		if (sm_we)
			smin_mem[sm_waddr] <= sm_wdata;
		sm_rdata_q <= smin_mem[sm_raddr];
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			thr_q        <= '0;
			running_q    <= '0;
			count_q      <= '0;
			drop_q       <= 1'b0;
			left_q       <= '0;
			right_q      <= '0;
			best_q       <= '0;
			out_valid_q  <= 1'b0;
			sfx_valid_s1 <= 1'b0;
		end else begin
			if (cfg_wr)
				thr_q <= pwdata[SUM_W-1:0];

			if (emit_go)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_LOAD: begin
					if (in_fire) begin
						if (has_room) begin
							running_q <= new_sum;
							count_q   <= count_q + 1'b1;
						end else begin
							drop_q <= 1'b1;
						end
						if (is_last)
							state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (running_q <= thr_q)
						state_q <= ST_EMIT;
					else
						state_q <= ST_SUFFIX;
				end
				ST_SUFFIX: begin
					sfx_valid_s1 <= (rd_idx_q != '0);
					if (rd_idx_q == '0 && !sfx_valid_s1)
						state_q <= ST_PRIME;
				end
				ST_PRIME: begin
					left_q  <= '0;
					right_q <= '0;
					best_q  <= '0;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (walk_more) begin
						if (fits) begin
							right_q <= r_plus1;
							if (longer)
								best_q <= span[LEN_W-1:0];
						end else begin
							left_q <= l_plus1;
						end
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						running_q <= '0;
						count_q   <= '0;
						drop_q    <= 1'b0;
						state_q   <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_CHECK: begin
				result_len_q <= LEN_W'(count_q);
				smin_q       <= running_q;
				rd_idx_q     <= ADDR_W'(count_q - 1'b1);
			end
			ST_SUFFIX: begin
				if (rd_idx_q != '0) begin
					rd_idx_q    <= rd_idx_q - 1'b1;
					sfx_addr_s1 <= rd_idx_q - 1'b1;
				end
				if (sfx_valid_s1)
					smin_q <= sfx_min;
			end
			ST_PRIME: begin
				curp_q <= '0;
			end
			ST_WALK: begin
				if (walk_more) begin
					if (fits)
						smin_q <= sm_rdata_q;
					else
						curp_q <= p_rdata_q;
				end else begin
					result_len_q <= best_q;
				end
			end
			default: begin
			end
		endcase

		if (emit_go) begin
			best_length_q <= result_len_q;
			overflowed_q  <= drop_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign best_length = best_length_q;
	assign overflowed  = overflowed_q;

endmodule

// ----- hdl/lss_checker.sv -----
`timescale 1ns / 1ps

module lss_checker
	import lss_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             is_last,
	input logic             out_valid,
	input logic             out_ready,
	input logic [LEN_W-1:0] best_length,
	input logic             overflowed
);

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(best_length) && $stable(overflowed))
		else $error("result payload changed while stalled");

	// The last transaction of an array closes the input while it is resolved
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && is_last |=> !in_ready)
		else $error("input still open after last sample");

	// A new result only follows a resolve phase with the input closed
	a_result_after_resolve: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a resolve phase");

	// A length never exceeds the store depth
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> best_length <= LEN_W'(MAX_ELEMENTS))
		else $error("result length out of range");

endmodule

bind longest_subarray_sum_at_most_k lss_checker u_lss_checker (.*);

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import lss_pkg::*;

	localparam sum_t THRESH_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam sum_t THRESH_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	// shapes of random sample streams
	typedef enum int {MIX_FULL, MIX_SMALL, MIX_POSITIVE, MIX_EXTREME} sample_mix_t;

	typedef struct packed {
		logic [LEN_W-1:0] length;
		logic             overflow;
	} run_result_t;

	// Tracks the array being loaded and the runs expected back from the block
	class run_length_board;
		sum_t        limit;
		sum_t        running;
		sum_t        prefix[MAX_ELEMENTS];
		sum_t        tail_min[MAX_ELEMENTS];
		int          count;
		bit          dropped;
		run_result_t expected_runs[$];
		int          bad_count;

		function new();
			limit     = '0;
			running   = '0;
			count     = 0;
			dropped   = 1'b0;
			bad_count = 0;
		endfunction

		function void set_threshold(sum_t value);
			limit = value;
		endfunction

		// longest span of stored samples whose sum stays at or under the limit
		function logic [LEN_W-1:0] longest_run();
			int    n;
			int    lo;
			int    hi;
			int    best;
			int    i;
			diff_t gap;
			n    = count;
			best = 0;
			lo   = 0;
			hi   = 0;
			if (n == 0)
				return '0;
			// whole array already fits
			if (prefix[n-1] <= limit)
				return LEN_W'(n);
			// minimum prefix from each position to the end
			tail_min[n-1] = prefix[n-1];
			for (i = n - 1; i > 0; i--)
				tail_min[i-1] = (prefix[i-1] < tail_min[i]) ? prefix[i-1] : tail_min[i];
			// two-pointer sweep
			while (lo < n && hi < n) begin
				gap = tail_min[hi];
				if (lo > 0)
					gap = gap - prefix[lo-1];
				if (gap <= limit) begin
					if (hi + 1 > lo && hi + 1 - lo > best)
						best = hi + 1 - lo;
					hi++;
				end else begin
					lo++;
				end
			end
			return LEN_W'(best);
		endfunction

		function void note_input(logic signed [SAMPLE_W-1:0] value, logic last);
			run_result_t res;
			if (count < MAX_ELEMENTS) begin
				running       = running + value;
				prefix[count] = running;
				count++;
			end else begin
				dropped = 1'b1;
			end
			if (last) begin
				res.length   = longest_run();
				res.overflow = dropped;
				expected_runs.push_back(res);
				running = '0;
				count   = 0;
				dropped = 1'b0;
			end
		endfunction

		function void check_result(logic [LEN_W-1:0] length, logic overflow);
			run_result_t exp_res;
			if (expected_runs.size() == 0) begin
				bad_count++;
				if (bad_count <= 10)
					$display("unexpected result: best_length %0d overflowed %0b", length, overflow);
				return;
			end
			exp_res = expected_runs.pop_front();
			if (exp_res.length !== length || exp_res.overflow !== overflow) begin
				bad_count++;
				if (bad_count <= 10)
					$display("mismatch: best_length exp %0d got %0d, overflowed exp %0b got %0b",
						exp_res.length, length, exp_res.overflow, overflow);
			end
		endfunction

		function int pending();
			return expected_runs.size();
		endfunction

		function bit clean();
			if (expected_runs.size() != 0)
				$display("%0d results never arrived", expected_runs.size());
			return bad_count == 0 && expected_runs.size() == 0;
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                  is_last;
	logic                  out_valid;
	logic                  out_ready;
	logic [LEN_W-1:0]      best_length;
	logic                  overflowed;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	bit              steady;
	run_length_board board = new();

	longest_subarray_sum_at_most_k DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample      (sample),
		.is_last     (is_last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.best_length (best_length),
		.overflowed  (overflowed),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// result side: check each transaction, stall now and then
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result(best_length, overflowed);
		out_ready <= steady || ($urandom_range(0, 99) >= 9);
	end

	task automatic send_item(logic signed [SAMPLE_W-1:0] value, logic last);
		if (!steady) begin
			while ($urandom_range(0, 99) < 9) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		sample   <= value;
		is_last  <= last;
		do @(posedge clk); while (!in_ready);
		board.note_input(value, last);
	endtask

	// hold off until every result is back and the block has settled
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_threshold(sum_t value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_THRESHOLD, 2'b00};
		pwdata  <= APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		board.set_threshold(value);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] make_sample(sample_mix_t mix);
		case (mix)
			MIX_SMALL:    return SAMPLE_W'($urandom_range(0, 400)) - 16'sd200;
			MIX_POSITIVE: return SAMPLE_W'($urandom_range(0, 300)) - 16'sd100;
			MIX_EXTREME: begin
				case ($urandom_range(0, 4))
					0: return 16'sh7FFF;
					1: return 16'sh8000;
					2: return 16'sd0;
					3: return -16'sd1;
					default: return 16'sd1;
				endcase
			end
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic sum_t choose_threshold();
		case ($urandom_range(0, 5))
			0: return sum_t'($urandom_range(0, 2000)) - sum_t'(1000);
			1: return sum_t'($urandom_range(0, 200000)) - sum_t'(100000);
			2: return sum_t'($urandom);
			3: return THRESH_MAX;
			4: return THRESH_MIN;
			default: return sum_t'($urandom_range(0, 20)) - sum_t'(10);
		endcase
	endfunction

	task automatic send_array(int n, sample_mix_t mix);
		for (int i = 0; i < n; i++)
			send_item(make_sample(mix), i == n - 1);
	endtask

	task automatic send_constant(int n, logic signed [SAMPLE_W-1:0] value);
		for (int i = 0; i < n; i++)
			send_item(value, i == n - 1);
	endtask

	initial begin
		int          random_items;
		int          phase;
		int          arrays;
		int          len;
		sample_mix_t mix;

		arst_n   = 1'b0;
		in_valid = 1'b0;
		sample   = '0;
		is_last  = 1'b0;
		out_ready = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		steady   = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: single elements, zero results, early case, walk
		write_threshold('0);
		send_item(16'sd0, 1'b1);
		send_item(16'sh7FFF, 1'b1);
		send_item(16'sh8000, 1'b1);
		send_item(16'sd1, 1'b0); send_item(16'sd1, 1'b0); send_item(16'sd1, 1'b1);
		send_item(16'sd5, 1'b0); send_item(-16'sd2, 1'b0); send_item(16'sd6, 1'b0);
		send_item(-16'sd7, 1'b0); send_item(16'sd1, 1'b1);
		send_item(16'sh7FFF, 1'b0); send_item(16'sh8000, 1'b0); send_item(16'sh7FFF, 1'b0);
		send_item(16'sh7FFF, 1'b0); send_item(-16'sd1, 1'b0); send_item(16'sd1, 1'b1);
		wait_idle();
		write_threshold(sum_t'(10));
		send_item(16'sd4, 1'b0); send_item(16'sd4, 1'b0); send_item(16'sd4, 1'b0);
		send_item(-16'sd20, 1'b0); send_item(16'sd30, 1'b0); send_item(16'sd2, 1'b0);
		send_item(16'sd2, 1'b1);
		wait_idle();

		// full store with a full walk; two dropped, the last one among them,
		// then a short array with the flag cleared
		write_threshold('0);
		send_array(MAX_ELEMENTS + 2, MIX_FULL);
		send_array(5, MIX_SMALL);
		wait_idle();

		// random phases, each with its own threshold
		random_items = 0;
		phase = 0;
		while (random_items < 300) begin
			wait_idle();
			write_threshold(choose_threshold());
			steady = (phase == 1);
			arrays = $urandom_range(3, 8);
			repeat (arrays) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 100) :
					$urandom_range(1, 24);
				mix = sample_mix_t'($urandom_range(0, 3));
				send_array(len, mix);
				random_items += len;
			end
			phase++;
		end
		steady = 1'b0;

		wait_idle();
		repeat (100) @(posedge clk);
		if (board.clean())
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- longest_subarray_sum_at_most_k.f -----
hdl/lss_pkg.sv
hdl/longest_subarray_sum_at_most_k.sv
hdl/lss_checker.sv
bench/testbench.sv
